// ===== sv/aar_pkg.sv =====
// Shared types, constants and rounding helper for the axis-angle rotation block.
package aar_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int N2_W         = 32;                 // width of |v|^2
  localparam int SQRT_STEPS   = N2_W;               // one root bit per stage
  localparam int DIV_STEPS    = 31;                 // quotient bits of a unit component
  localparam int NORM_LAT     = SQRT_STEPS + DIV_STEPS + 1;
  localparam int ALIGN_STAGES = NORM_LAT - CORDIC_STEPS - 1;

  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

  localparam logic signed [33:0] ATAN_Q30 [CORDIC_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd8, 34'sd4, 34'sd2
  };

  typedef struct packed {
    logic signed [33:0] z;
    logic               neg;
    logic [N2_W-1:0]    n2;
    logic [2:0][15:0]   mag;
    logic [2:0]         sgn;
    logic               zero;
  } item_t;

  typedef struct packed {
    logic signed [33:0] s;
    logic signed [33:0] c;
    logic signed [33:0] t;
  } trig_t;

  // Q30 x Q30 product back to Q30, round half up
  function automatic logic signed [35:0] rnd30(input logic signed [69:0] p);
    logic signed [69:0] a;
    a = p + 70'sd536870912;
    return a[65:30];
  endfunction

endpackage

// ===== sv/aar_front.sv =====
// Front end: takes a request, reduces the angle and squares the axis.
module aar_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic signed [15:0]   angle,
  input  logic signed [15:0]   axis_x,
  input  logic signed [15:0]   axis_y,
  input  logic signed [15:0]   axis_z,
  output logic                 item_valid,
  output aar_pkg::item_t       item
);
  import aar_pkg::*;

  logic signed [33:0] z_raw;
  logic signed [31:0] sq_x, sq_y, sq_z;
  logic [N2_W-1:0]    n2;
  item_t              item_next;

  assign z_raw = $signed({angle[15], angle, 17'b0});
  assign sq_x  = axis_x * axis_x;
  assign sq_y  = axis_y * axis_y;
  assign sq_z  = axis_z * axis_z;
  assign n2    = {1'b0, sq_x[30:0]} + {1'b0, sq_y[30:0]} + {1'b0, sq_z[30:0]};

  always_comb begin
    item_next = '0;
    if (z_raw > Q30_HALF_PI) begin
      item_next.z   = z_raw - Q30_PI;
      item_next.neg = 1'b1;
    end else if (z_raw < -Q30_HALF_PI) begin
      item_next.z   = z_raw + Q30_PI;
      item_next.neg = 1'b1;
    end else begin
      item_next.z   = z_raw;
      item_next.neg = 1'b0;
    end
    item_next.n2     = n2;
    item_next.mag[0] = axis_x[15] ? 16'(-axis_x) : 16'(axis_x);
    item_next.mag[1] = axis_y[15] ? 16'(-axis_y) : 16'(axis_y);
    item_next.mag[2] = axis_z[15] ? 16'(-axis_z) : 16'(axis_z);
    item_next.sgn    = {axis_z[15], axis_y[15], axis_x[15]};
    item_next.zero   = (n2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// ===== sv/aar_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
module aar_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aar_pkg::item_t push_item,
  output logic           head_valid,
  output aar_pkg::item_t head,
  output logic           full
);
  import aar_pkg::*;

  item_t      mem [2];
  logic       wr, rd;
  logic [1:0] cnt, cnt_next;
  logic       pop;

  // back end never stalls, so the head leaves every cycle it is present
  assign pop        = (cnt != 2'd0);
  assign head_valid = pop;
  assign head       = mem[rd];
  assign full       = (cnt == 2'd2);

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop)  rd <= ~rd;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_item;
    end
  end

endmodule

// ===== sv/aar_sincos.sv =====
// Pipelined CORDIC for sin, cos and 1 - cos, plus delay to line up with the normalizer.
module aar_sincos (
  input  logic               clk,
  input  logic signed [33:0] z_in,
  input  logic               neg_in,
  output aar_pkg::trig_t     trig
);
  import aar_pkg::*;

  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [33:0] cz [CORDIC_STEPS+1];
  logic               cneg [CORDIC_STEPS+1];
  trig_t              dly [ALIGN_STAGES+1];

  assign cx[0]   = INV_GAIN;
  assign cy[0]   = '0;
  assign cz[0]   = z_in;
  assign cneg[0] = neg_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN_Q30[i];
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN_Q30[i];
      end
      cneg[i+1] <= cneg[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cneg[CORDIC_STEPS]) begin
      dly[0].s <= -cy[CORDIC_STEPS];
      dly[0].c <= -cx[CORDIC_STEPS];
      dly[0].t <= Q30_ONE + cx[CORDIC_STEPS];
    end else begin
      dly[0].s <= cy[CORDIC_STEPS];
      dly[0].c <= cx[CORDIC_STEPS];
      dly[0].t <= Q30_ONE - cx[CORDIC_STEPS];
    end
  end

  for (genvar k = 0; k < ALIGN_STAGES; k++) begin : g_dly
    always_ff @(posedge clk) begin
      dly[k+1] <= dly[k];
    end
  end

  assign trig = dly[ALIGN_STAGES];

endmodule

// ===== sv/aar_norm.sv =====
// Axis normalizer: pipelined integer square root, then three pipelined dividers.
module aar_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  aar_pkg::item_t     in_item,
  output logic               u_valid,
  output logic               u_zero,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy,
  output logic signed [31:0] uz
);
  import aar_pkg::*;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       sgn;
    logic [2:0][15:0] mag;
  } carry_t;

  // square root of n2 * 2^32, two radicand bits per stage
  logic [N2_W-1:0] sq_n2   [SQRT_STEPS+1];
  logic [34:0]     sq_rem  [SQRT_STEPS+1];
  logic [31:0]     sq_root [SQRT_STEPS+1];
  carry_t          sq_cy   [SQRT_STEPS+1];

  assign sq_n2[0]   = in_item.n2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_cy[0]   = '{valid: in_valid, zero: in_item.zero, sgn: in_item.sgn,
                        mag: in_item.mag};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [1:0]  pair;
    logic [34:0] rem2, trial;
    if (k < N2_W / 2) begin : g_hi
      assign pair = sq_n2[k][N2_W-1-2*k -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end
    assign rem2  = {sq_rem[k][32:0], pair};
    assign trial = {1'b0, sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rem2 >= trial) begin
        sq_rem[k+1]  <= rem2 - trial;
        sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
      end else begin
        sq_rem[k+1]  <= rem2;
        sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
      end
      sq_n2[k+1]       <= sq_n2[k];
      sq_cy[k+1].zero  <= sq_cy[k].zero;
      sq_cy[k+1].sgn   <= sq_cy[k].sgn;
      sq_cy[k+1].mag   <= sq_cy[k].mag;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_cy[k+1].valid <= 1'b0;
      end else begin
        sq_cy[k+1].valid <= sq_cy[k].valid;
      end
    end
  end

  // q = (|v| * 2^46 + r/2) / r; the quotient fits 31 bits, so the top of the
  // numerator seeds the remainder directly
  logic [31:0]       dv_r   [DIV_STEPS+1];
  logic [2:0][31:0]  dv_rem [DIV_STEPS+1];
  logic [2:0][30:0]  dv_low [DIV_STEPS+1];
  logic [2:0][30:0]  dv_q   [DIV_STEPS+1];
  carry_t            dv_cy  [DIV_STEPS+1];

  assign dv_r[0]  = sq_root[SQRT_STEPS];
  assign dv_cy[0] = sq_cy[SQRT_STEPS];

  for (genvar l = 0; l < 3; l++) begin : g_seed
    logic [61:0] num;
    assign num          = {sq_cy[SQRT_STEPS].mag[l], 46'b0}
                        + {31'b0, sq_root[SQRT_STEPS][31:1]};
    assign dv_rem[0][l] = {1'b0, num[61:31]};
    assign dv_low[0][l] = num[30:0];
    assign dv_q[0][l]   = '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] rem2;
      assign rem2 = {dv_rem[j][l], dv_low[j][l][DIV_STEPS-1-j]};
      always_ff @(posedge clk) begin
        if (rem2 >= {1'b0, dv_r[j]}) begin
          dv_rem[j+1][l] <= 32'(rem2 - {1'b0, dv_r[j]});
          dv_q[j+1][l]   <= {dv_q[j][l][29:0], 1'b1};
        end else begin
          dv_rem[j+1][l] <= rem2[31:0];
          dv_q[j+1][l]   <= {dv_q[j][l][29:0], 1'b0};
        end
        dv_low[j+1][l] <= dv_low[j][l];
      end
    end

    always_ff @(posedge clk) begin
      dv_r[j+1]       <= dv_r[j];
      dv_cy[j+1].zero <= dv_cy[j].zero;
      dv_cy[j+1].sgn  <= dv_cy[j].sgn;
      dv_cy[j+1].mag  <= dv_cy[j].mag;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_cy[j+1].valid <= 1'b0;
      end else begin
        dv_cy[j+1].valid <= dv_cy[j].valid;
      end
    end
  end

  function automatic logic signed [31:0] apply_sign(input logic zero, input logic sgn,
                                                    input logic [30:0] q);
    logic signed [31:0] v;
    v = $signed({1'b0, q});
    if (zero) begin
      return '0;
    end
    return sgn ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    ux     <= apply_sign(dv_cy[DIV_STEPS].zero, dv_cy[DIV_STEPS].sgn[0], dv_q[DIV_STEPS][0]);
    uy     <= apply_sign(dv_cy[DIV_STEPS].zero, dv_cy[DIV_STEPS].sgn[1], dv_q[DIV_STEPS][1]);
    uz     <= apply_sign(dv_cy[DIV_STEPS].zero, dv_cy[DIV_STEPS].sgn[2], dv_q[DIV_STEPS][2]);
    u_zero <= dv_cy[DIV_STEPS].zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
    end else begin
      u_valid <= dv_cy[DIV_STEPS].valid;
    end
  end

endmodule

// ===== sv/aar_matrix.sv =====
// Rodrigues matrix: products, rounding, sums and output saturation.
module aar_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_zero,
  input  logic signed [31:0] ux,
  input  logic signed [31:0] uy,
  input  logic signed [31:0] uz,
  input  aar_pkg::trig_t     trig,
  output logic               done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic               zero_axis
);
  import aar_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [37:0] RND =
    (SH > 0) ? (38'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 38'sd0;

  function automatic logic signed [15:0] to_out(input logic signed [36:0] e);
    logic signed [37:0] v;
    v = ($signed({e[36], e}) + RND) >>> SH;
    if (v > 38'sd32767) begin
      return 16'sh7fff;
    end else if (v < -38'sd32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  // stage 1: raw products
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [65:0] psx, psy, psz;
  logic signed [33:0] c1, t1;
  logic               v1, z1;
  // stage 2: rounded pairs times (1 - cos), and rounded sine terms
  logic signed [69:0] qxx, qyy, qzz, qxy, qxz, qyz;
  logic signed [35:0] sx2, sy2, sz2;
  logic signed [33:0] c2;
  logic               v2, z2;
  // stage 3 sums
  logic signed [35:0] xx, yy, zz, xy, xz, yz;

  always_ff @(posedge clk) begin
    pxx <= ux * ux;
    pyy <= uy * uy;
    pzz <= uz * uz;
    pxy <= ux * uy;
    pxz <= ux * uz;
    pyz <= uy * uz;
    psx <= ux * trig.s;
    psy <= uy * trig.s;
    psz <= uz * trig.s;
    c1  <= trig.c;
    t1  <= trig.t;
    z1  <= in_zero;
  end

  always_ff @(posedge clk) begin
    qxx <= rnd30({{6{pxx[63]}}, pxx}) * t1;
    qyy <= rnd30({{6{pyy[63]}}, pyy}) * t1;
    qzz <= rnd30({{6{pzz[63]}}, pzz}) * t1;
    qxy <= rnd30({{6{pxy[63]}}, pxy}) * t1;
    qxz <= rnd30({{6{pxz[63]}}, pxz}) * t1;
    qyz <= rnd30({{6{pyz[63]}}, pyz}) * t1;
    sx2 <= rnd30({{4{psx[65]}}, psx});
    sy2 <= rnd30({{4{psy[65]}}, psy});
    sz2 <= rnd30({{4{psz[65]}}, psz});
    c2  <= c1;
    z2  <= z1;
  end

  assign xx = rnd30(qxx);
  assign yy = rnd30(qyy);
  assign zz = rnd30(qzz);
  assign xy = rnd30(qxy);
  assign xz = rnd30(qxz);
  assign yz = rnd30(qyz);

  always_ff @(posedge clk) begin
    m00       <= to_out(37'(c2) + 37'(xx));
    m01       <= to_out(37'(xy) - 37'(sz2));
    m02       <= to_out(37'(xz) + 37'(sy2));
    m10       <= to_out(37'(xy) + 37'(sz2));
    m11       <= to_out(37'(c2) + 37'(yy));
    m12       <= to_out(37'(yz) - 37'(sx2));
    m20       <= to_out(37'(xz) - 37'(sy2));
    m21       <= to_out(37'(yz) + 37'(sx2));
    m22       <= to_out(37'(c2) + 37'(zz));
    zero_axis <= z2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule

// ===== sv/axis_angle_rotation_matrix_top.sv =====
// Axis-angle to 3x3 rotation matrix, top level.
// Takes one request per clock: busy stays low in normal use, since the
// arithmetic pipeline never holds. Each result shows on the m* ports for one
// cycle with done high; how long after its request it comes is set by the
// normalizer (32-stage square root and 31-stage dividers), with the 30-stage
// CORDIC padded to match. A zero axis gives cos on the diagonal, zeros
// elsewhere, and zero_axis high.
module axis_angle_rotation_matrix_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic               zero_axis
);
  import aar_pkg::*;

  logic               accept;
  logic               f_valid, q_valid, u_valid, u_zero;
  item_t              f_item, q_item;
  trig_t              trig;
  logic signed [31:0] ux, uy, uz;

  assign accept = start && !busy;

  aar_front u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .item_valid(f_valid), .item(f_item)
  );

  aar_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .push_item(f_item),
    .head_valid(q_valid), .head(q_item), .full(busy)
  );

  aar_sincos u_sincos (
    .clk(clk), .z_in(q_item.z), .neg_in(q_item.neg), .trig(trig)
  );

  aar_norm u_norm (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item),
    .u_valid(u_valid), .u_zero(u_zero), .ux(ux), .uy(uy), .uz(uz)
  );

  aar_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst), .in_valid(u_valid), .in_zero(u_zero),
    .ux(ux), .uy(uy), .uz(uz), .trig(trig),
    .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
    .m12(m12), .m20(m20), .m21(m21), .m22(m22), .zero_axis(zero_axis)
  );

  // the back end drains the queue every cycle, so it can never fill
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("request queue filled");

  a_zero_offdiag: assert property (@(posedge clk) disable iff (rst)
    done && zero_axis |-> m01 == 16'sd0 && m02 == 16'sd0 && m10 == 16'sd0 &&
                          m12 == 16'sd0 && m20 == 16'sd0 && m21 == 16'sd0)
    else $error("zero axis gave nonzero off-diagonal entry");

  a_zero_diag: assert property (@(posedge clk) disable iff (rst)
    done && zero_axis |-> m00 == m11 && m11 == m22)
    else $error("zero axis gave unequal diagonal");

endmodule

// ===== dv/axis_angle_rotation_matrix_top_test.sv =====
// Self-checking testbench for the axis-angle to rotation matrix block.
module axis_angle_rotation_matrix_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_axis;
  logic signed [15:0] angle = '0, axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } matrix_t;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint GAIN_INV = 64'sd652032874;
  localparam int     WATCH_LIMIT = 5000;

  longint atan_tab [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2
  };

  matrix_t pending_matrices [$];
  int errors = 0;
  int n_sent = 0;
  int n_zero = 0;
  int idle_pct = 0;
  int idle_count = 0;

  axis_angle_rotation_matrix_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
    .m12(m12), .m20(m20), .m21(m21), .m22(m22), .zero_axis(zero_axis)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint v, longint unsigned r);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = ((mag << 46) + (r >> 1)) / r;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] to_q14(longint e);
    longint v;
    v = (e + (64'sd1 << 15)) >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [15:0] ang,
      logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az);
    matrix_t res;
    longint z, x, y, nx, s, c, t, ux, uy, uz, vx, vy, vz;
    longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
    longint unsigned n2, r;
    logic flip;
    z = longint'(ang) * 131072;
    x = GAIN_INV;
    y = 0;
    flip = 1'b0;
    if (z > HPI_Q30) begin z -= PI_Q30; flip = 1'b1; end
    else if (z < -HPI_Q30) begin z += PI_Q30; flip = 1'b1; end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE_Q30 - c;
    vx = ax; vy = ay; vz = az;
    n2 = vx * vx + vy * vy + vz * vz;
    ux = 0; uy = 0; uz = 0;
    res.zero = (n2 == 0);
    if (!res.zero) begin
      r = int_sqrt(n2 << 32);
      ux = unit_comp(vx, r);
      uy = unit_comp(vy, r);
      uz = unit_comp(vz, r);
    end
    xx = qmul(qmul(ux, ux), t);
    yy = qmul(qmul(uy, uy), t);
    zz = qmul(qmul(uz, uz), t);
    xy = qmul(qmul(ux, uy), t);
    xz = qmul(qmul(ux, uz), t);
    yz = qmul(qmul(uy, uz), t);
    sx = qmul(ux, s);
    sy = qmul(uy, s);
    sz = qmul(uz, s);
    res.m[0] = to_q14(c + xx);
    res.m[1] = to_q14(xy - sz);
    res.m[2] = to_q14(xz + sy);
    res.m[3] = to_q14(xy + sz);
    res.m[4] = to_q14(c + yy);
    res.m[5] = to_q14(yz - sx);
    res.m[6] = to_q14(xz - sy);
    res.m[7] = to_q14(yz + sx);
    res.m[8] = to_q14(c + zz);
    return res;
  endfunction

  // start stays high across back-to-back requests; only idling or draining lowers it
  task automatic send_request(logic signed [15:0] a, logic signed [15:0] x,
      logic signed [15:0] y, logic signed [15:0] z);
    logic taken;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      // geometric run of idle cycles keeps the idle share near idle_pct
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    angle <= a; axis_x <= x; axis_y <= y; axis_z <= z;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    pending_matrices.push_back(rotation_matrix(a, x, y, z));
    n_sent++;
    if (x == 0 && y == 0 && z == 0) n_zero++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  task automatic test_angle_extremes();
    logic signed [15:0] angs [8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
      16'shffff, 16'sd12868, -16'sd12868, 16'sd25736};
    foreach (angs[i]) send_request(angs[i], 16'sd1000, 16'sd0, 16'sd0);
    send_request(16'sd6434, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(16'sd6434, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(-16'sd3000, 16'sh8000, 16'sh7fff, 16'sh0001);
    send_request(16'sd9000, 16'sd0, 16'sd1, 16'sd0);
    send_request(16'sd9000, 16'sd0, 16'sd0, -16'sd1);
  endtask

  task automatic test_zero_axis();
    send_request(16'sh0000, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd25736, 16'sd0, 16'sd0, 16'sd0);
    send_request(-16'sd12868, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random(int count, int pct);
    logic signed [15:0] v [3];
    int sel;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      foreach (v[k]) begin
        case (sel)
          0, 1, 2, 3: v[k] = 16'($urandom);
          4, 5:       v[k] = $signed(16'($urandom_range(15))) - 16'sd8;
          6:          v[k] = ($urandom_range(2) == k) ? 16'($urandom) : 16'sd0;
          7:          v[k] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          8:          v[k] = 16'sd0;
          default:    v[k] = $signed(16'($urandom_range(511))) - 16'sd256;
        endcase
      end
      send_request(16'($urandom), v[0], v[1], v[2]);
      if (i == count / 2) drain_results();
    end
  endtask

  always @(posedge clk) begin
    logic signed [15:0] got [9];
    matrix_t exp_m;
    if (!rst && done) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (pending_matrices.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
      end else begin
        exp_m = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== exp_m.m[k]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     exp_m.m[k], got[k]);
            errors++;
          end
        if (zero_axis !== exp_m.zero) begin
          $display("%0t: zero_axis expected %0b actual %0b", $time, exp_m.zero,
                   zero_axis);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither a taken request nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCH_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_angle_extremes();
    test_zero_axis();
    test_random(400, 38);
    test_random(400, 54);
    test_random(420, 0);
    drain_results();
    repeat (100) @(posedge clk);
    if (pending_matrices.size() != 0) begin
      $display("%0d expected results never arrived", pending_matrices.size());
      errors++;
    end
    $display("Sent %0d requests (%0d with zero axis) under three idle mixes,", n_sent,
             n_zero);
    $display("with angle and axis extremes; %0d mismatches.", errors);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aar_pkg.sv
sv/aar_front.sv
sv/aar_queue.sv
sv/aar_sincos.sv
sv/aar_norm.sv
sv/aar_matrix.sv
sv/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_test.sv
